// File: rtl/core/slipd_pkg.sv
// ----------------------------------------------------------------------------
// slipd_pkg
// Types, codes and constants shared by the SLIP frame decoder and its
// header checker.
// ----------------------------------------------------------------------------
package slipd_pkg;

	localparam int unsigned MaxRawFrame = 256;
	localparam int unsigned HeaderBytes = 16;
	localparam int unsigned MinDecoded  = 18;
	localparam int unsigned RawW        = 11;
	localparam int unsigned DecW        = 9;

	localparam logic [RawW-1:0] RawSat = {RawW{1'b1}};
	localparam logic [DecW-1:0] DecSat = {DecW{1'b1}};

	localparam logic [7:0] ClassByte   = 8'd49;
	localparam logic [7:0] GroupMisc   = 8'd18;
	localparam logic [7:0] GroupTwo    = 8'd2;
	localparam logic [7:0] GroupThree  = 8'd3;
	localparam logic [7:0] TypeA       = 8'd98;
	localparam logic [7:0] TypeB       = 8'd100;
	localparam logic [7:0] TypeC       = 8'd102;
	localparam logic [7:0] TypeD       = 8'd107;

	localparam logic [7:0] FrameReset     = 8'd192;
	localparam logic [7:0] EscapeReset    = 8'd219;
	localparam logic [7:0] EscFrameReset  = 8'd220;
	localparam logic [7:0] EscEscapeReset = 8'd221;

	// configuration register indexes
	localparam logic [1:0] CfgFrameByte  = 2'd0;
	localparam logic [1:0] CfgEscapeByte = 2'd1;
	localparam logic [1:0] CfgEscFrame   = 2'd2;
	localparam logic [1:0] CfgEscEscape  = 2'd3;

	localparam logic KindData   = 1'b0;
	localparam logic KindStatus = 1'b1;

	typedef enum logic [2:0] {
		StOk          = 3'd0,
		StTooLong     = 3'd1,
		StTooShort    = 3'd2,
		StLenMismatch = 3'd3,
		StBadClass    = 3'd4,
		StUnknownReg  = 3'd5,
		StUnknownType = 3'd6
	} status_t;

	typedef logic [HeaderBytes-1:0][7:0] hdr_bytes_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] group;
		logic [7:0] number;
		logic [7:0] dtype;
		logic [7:0] count;
		logic [7:0] length;
	} hdr_chk_t;

endpackage

// File: rtl/core/slipd_hdr_check.sv
// ----------------------------------------------------------------------------
// slipd_hdr_check
// End of frame checks on the stored header bytes and the frame counters.
// ----------------------------------------------------------------------------
module slipd_hdr_check (
	input  slipd_pkg::hdr_bytes_t                 hdr,
	input  logic [slipd_pkg::RawW-1:0]            raw_count,
	input  logic [slipd_pkg::DecW-1:0]            decoded_count,
	output slipd_pkg::hdr_chk_t                   chk
);

	logic [15:0] len_field;
	logic [15:0] len_expect;
	logic        reg_known;
	logic        type_known;
	logic [7:0]  grp;
	logic [7:0]  num;

	assign len_field  = {hdr[1], hdr[0]};
	assign len_expect = 16'(decoded_count - slipd_pkg::DecW'(3));
	assign grp        = hdr[10];
	assign num        = hdr[12];

	always_comb begin
		if (grp == slipd_pkg::GroupMisc) begin
			reg_known = (hdr[11] == 8'd0) && (num == 8'd1) && (hdr[13] == 8'd0);
		end else if (grp == slipd_pkg::GroupTwo) begin
			reg_known = (num >= 8'd2) && (num <= 8'd12);
		end else if (grp == slipd_pkg::GroupThree) begin
			reg_known = (num == 8'd1) || ((num >= 8'd5) && (num <= 8'd10));
		end else begin
			reg_known = 1'b0;
		end
	end

	assign type_known = (hdr[14] == slipd_pkg::TypeA) || (hdr[14] == slipd_pkg::TypeB) ||
	                    (hdr[14] == slipd_pkg::TypeC) || (hdr[14] == slipd_pkg::TypeD);

	always_comb begin
		chk = '0;
		if (raw_count > slipd_pkg::RawW'(slipd_pkg::MaxRawFrame)) begin
			chk.status = slipd_pkg::StTooLong;
		end else if (decoded_count < slipd_pkg::DecW'(slipd_pkg::MinDecoded)) begin
			chk.status = slipd_pkg::StTooShort;
		end else begin
			if (len_field != len_expect) begin
				chk.status = slipd_pkg::StLenMismatch;
			end else if (hdr[9] != slipd_pkg::ClassByte) begin
				chk.status = slipd_pkg::StBadClass;
			end else if (!reg_known) begin
				chk.status = slipd_pkg::StUnknownReg;
			end else if (!type_known) begin
				chk.status = slipd_pkg::StUnknownType;
			end else begin
				chk.status = slipd_pkg::StOk;
			end
			chk.group  = hdr[10];
			chk.number = hdr[12];
			chk.dtype  = hdr[14];
			chk.count  = hdr[15];
		end
		// header fields stay zero for too long / too short frames
		chk.length = decoded_count[slipd_pkg::DecW-1] ? 8'hFF : decoded_count[7:0];
	end

endmodule

// File: rtl/core/slip_frame_decoder_header_check_top.sv
// ----------------------------------------------------------------------------
// slip_frame_decoder_header_check_top
// SLIP frame decoder with header check of the received frame.
// ----------------------------------------------------------------------------
// Input channel: one raw serial byte per transaction (rx_byte, in_valid,
// in_stall). Bytes are held in an input register, decoded by one pass of
// logic and the result lands in the output register (out_valid, out_stall).
// Each decoded byte gives one data transaction (kind 0) with its index; the
// closing delimiter gives one status transaction (kind 1) with the check
// result and header fields. Opening delimiter, escape bytes and bytes
// outside a frame give no transaction.
// Throughput: one byte per cycle unless in_stall is raised, set by the single decode
// pass between the input and output registers; a waiting result does not block
// bytes that give no result.
// Reset: hunting for a delimiter, counters cleared, registers at defaults
// (192, 219, 220, 221). The header bytes are not reset.
// Stall: while out_stall holds a result, a byte that would give a result
// waits in the input register and in_stall is raised.
// Configuration: cfg_we/cfg_index/cfg_data; the user must write it only when idle (not enforced).
// ----------------------------------------------------------------------------
module slip_frame_decoder_header_check_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] data_byte,
	output logic [7:0] byte_index,
	output logic [2:0] status,
	output logic [7:0] register_group,
	output logic [7:0] register_number,
	output logic [7:0] data_type,
	output logic [7:0] element_count,
	output logic [7:0] frame_length
);

	typedef enum logic [1:0] {
		ModeIdle,
		ModeFrame,
		ModeEsc
	} mode_t;

	logic [7:0] frame_byte_q;
	logic [7:0] escape_byte_q;
	logic [7:0] esc_frame_q;
	logic [7:0] esc_escape_q;

	mode_t                         mode_q;
	logic [slipd_pkg::RawW-1:0]    raw_count_q;
	logic [slipd_pkg::DecW-1:0]    dec_count_q;
	slipd_pkg::hdr_bytes_t         hdr_q;

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic                          in_acc;
	logic                          out_free;
	logic                          adv;
	logic                          has_result;
	logic                          is_frame;
	logic                          emit_data;
	logic [7:0]                    data_val;
	logic [slipd_pkg::RawW-1:0]    raw_next;
	slipd_pkg::hdr_chk_t           chk;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign is_frame = (byte_s1 == frame_byte_q);
	assign raw_next = (raw_count_q == slipd_pkg::RawSat) ? raw_count_q
	                                                      : raw_count_q + 1'b1;

	always_comb begin
		emit_data = 1'b0;
		data_val  = byte_s1;
		if (mode_q == ModeEsc && !is_frame) begin
			emit_data = 1'b1;
			if (byte_s1 == esc_frame_q) begin
				data_val = frame_byte_q;
			end else if (byte_s1 == esc_escape_q) begin
				data_val = escape_byte_q;
			end
		end else if (mode_q == ModeFrame && !is_frame && byte_s1 != escape_byte_q) begin
			emit_data = 1'b1;
		end
	end

	assign has_result = (mode_q != ModeIdle) && (is_frame || emit_data);
	assign adv        = valid_s1 && (!has_result || out_free);
	assign in_stall   = valid_s1 && !adv;

	slipd_hdr_check u_hdr_check (
		.hdr           (hdr_q),
		.raw_count     (raw_next),
		.decoded_count (dec_count_q),
		.chk           (chk)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_byte_q  <= slipd_pkg::FrameReset;
			escape_byte_q <= slipd_pkg::EscapeReset;
			esc_frame_q   <= slipd_pkg::EscFrameReset;
			esc_escape_q  <= slipd_pkg::EscEscapeReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slipd_pkg::CfgFrameByte:  frame_byte_q  <= cfg_data;
				slipd_pkg::CfgEscapeByte: escape_byte_q <= cfg_data;
				slipd_pkg::CfgEscFrame:   esc_frame_q   <= cfg_data;
				slipd_pkg::CfgEscEscape:  esc_escape_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= rx_byte;
		end
	end

	// receive state machine and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ModeIdle;
			raw_count_q <= '0;
			dec_count_q <= '0;
		end else if (adv) begin
			unique case (mode_q)
				ModeIdle: begin
					if (is_frame) begin
						mode_q      <= ModeFrame;
						raw_count_q <= slipd_pkg::RawW'(1);
						dec_count_q <= '0;
					end
				end
				ModeFrame, ModeEsc: begin
					raw_count_q <= raw_next;
					if (is_frame) begin
						mode_q <= ModeIdle;
					end else if (emit_data) begin
						mode_q <= ModeFrame;
					end else begin
						mode_q <= ModeEsc;
					end
					if (emit_data && dec_count_q != slipd_pkg::DecSat) begin
						dec_count_q <= dec_count_q + 1'b1;
					end
				end
				default: mode_q <= ModeIdle;
			endcase
		end
	end

	// header bytes, written at fixed slots while the frame is short
	always_ff @(posedge clk) begin
		if (adv && emit_data && dec_count_q < slipd_pkg::DecW'(slipd_pkg::HeaderBytes)) begin
			hdr_q[dec_count_q[3:0]] <= data_val;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv && has_result) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_result) begin
			if (emit_data) begin
				kind            <= slipd_pkg::KindData;
				data_byte       <= data_val;
				byte_index      <= dec_count_q[7:0];
				status          <= 3'd0;
				register_group  <= '0;
				register_number <= '0;
				data_type       <= '0;
				element_count   <= '0;
				frame_length    <= '0;
			end else begin
				kind            <= slipd_pkg::KindStatus;
				data_byte       <= '0;
				byte_index      <= '0;
				status          <= 3'(chk.status);
				register_group  <= chk.group;
				register_number <= chk.number;
				data_type       <= chk.dtype;
				element_count   <= chk.count;
				frame_length    <= chk.length;
			end
		end
	end

endmodule
